@@ sv/gpc_pkg.sv @@
// Shared types, constants and helper functions for the grid pole classifier.
// Used by every module of the block but gpc_ram, and by its checker; depends on nothing.
package gpc_pkg;

	localparam int SLOT_BITS   = 10;
	localparam int CELL_SLOTS  = 1 << SLOT_BITS;
	localparam int HASH_BITS   = 10;
	localparam int COUNT_BITS  = 16;
	localparam int SUM_BITS    = 48;
	localparam int DIFF_BITS   = SUM_BITS + 1;
	localparam int IDX_BITS    = (HASH_BITS < SLOT_BITS) ? HASH_BITS : SLOT_BITS;
	localparam int CMP_BITS    = (COUNT_BITS > 16) ? COUNT_BITS : 16;
	localparam int DCNT_BITS   = $clog2(SUM_BITS);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int NBR_COUNT   = 8;

	localparam logic [31:0] HASH_MUL_X = 32'd73856093;
	localparam logic [31:0] HASH_MUL_Y = 32'd19349663;
	localparam logic [31:0] HASH_MASK  = (32'd1 << 20) - 32'd1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [30:0] RST_CELL_SIZE = 31'd65536;
	localparam logic signed [31:0] RST_MIN_REL = 32'sd13107;
	localparam logic signed [31:0] RST_MAX_REL = 32'sd196608;
	localparam logic [15:0] RST_MIN_PTS  = 16'd3;
	localparam logic [3:0]  RST_MIN_PASS = 4'd4;

	typedef enum logic [1:0] {
		OP_CLEAR    = 2'd0,
		OP_ACCUM    = 2'd1,
		OP_CLASSIFY = 2'd2,
		OP_NONE     = 2'd3
	} op_e;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_POLE     = 3'd2,
		ST_NOT_POLE = 3'd3,
		ST_FEW      = 3'd4,
		ST_ABSENT   = 3'd5
	} status_e;

	typedef enum logic [2:0] {
		CFG_CELL_SIZE = 3'd0,
		CFG_MIN_REL   = 3'd1,
		CFG_MAX_REL   = 3'd2,
		CFG_MIN_PTS   = 3'd3,
		CFG_MIN_PASS  = 3'd4
	} cfg_idx_e;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] pass_count;
	} out_item_t;

	typedef struct packed {
		logic [30:0]        cell_size;
		logic signed [31:0] min_rel;
		logic signed [31:0] max_rel;
		logic [15:0]        min_pts;
		logic [3:0]         min_pass;
	} cfg_t;

	// One queue entry: the operation with its cell index already worked out.
	typedef struct packed {
		logic [1:0]         opcode;
		logic [31:0]        cx;
		logic [31:0]        cy;
		logic signed [31:0] z;
	} job_t;

	typedef struct packed {
		logic                       valid;
		logic [31:0]                cx;
		logic [31:0]                cy;
		logic [COUNT_BITS-1:0]      count;
		logic signed [SUM_BITS-1:0] sum;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	// Neighbor k walks dx = -1..1 outer, dy = -1..1 inner, skipping the center.
	function automatic logic [31:0] nbr_dx(input logic [2:0] k);
		logic [31:0] d;
		case (k)
			3'd0, 3'd1, 3'd2: d = 32'hFFFF_FFFF;
			3'd3, 3'd4:       d = 32'd0;
			default:          d = 32'd1;
		endcase
		return d;
	endfunction

	function automatic logic [31:0] nbr_dy(input logic [2:0] k);
		logic [31:0] d;
		case (k)
			3'd0, 3'd3, 3'd5: d = 32'hFFFF_FFFF;
			3'd1, 3'd6:       d = 32'd0;
			default:          d = 32'd1;
		endcase
		return d;
	endfunction

endpackage

@@ sv/gpc_ram.sv @@
// Generic single-port RAM with a registered read port.
// Stands alone; the slot table of the classifier is built from it.
module gpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/gpc_fifo.sv @@
// Short job queue between the front and back parts of the classifier.
// Depends on gpc_pkg for the job type and the queue depth.
module gpc_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  gpc_pkg::job_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output gpc_pkg::job_t pop_data
);

	gpc_pkg::job_t                 entry_q [gpc_pkg::QUEUE_DEPTH];
	logic [gpc_pkg::QPTR_BITS-1:0] wr_ptr_q;
	logic [gpc_pkg::QPTR_BITS-1:0] rd_ptr_q;
	logic [gpc_pkg::QPTR_BITS:0]   cnt_q;
	logic                          do_push;
	logic                          do_pop;

	assign push_ready = cnt_q != (gpc_pkg::QPTR_BITS + 1)'(gpc_pkg::QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/gpc_front.sv @@
// Front part: takes an item, divides x and y by the cell size one bit per
// cycle and queues the job. Depends on gpc_pkg.
module gpc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  gpc_pkg::in_item_t item,
	input  gpc_pkg::cfg_t    cfg,
	output logic             idle,
	output logic             push_valid,
	input  logic             push_ready,
	output gpc_pkg::job_t    push_data
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t            state_q;
	logic [4:0]         dcnt_q;
	logic [30:0]        dvs_q;
	logic [31:0]        qx_q, qy_q;
	logic [30:0]        rx_q, ry_q;
	logic               negx_q, negy_q;
	logic [1:0]         op_q;
	logic signed [31:0] z_q;

	logic [31:0] x_abs, y_abs, tx, ty;
	logic        gex, gey;

	assign x_abs = item.point_x[31] ? 32'(-item.point_x) : item.point_x;
	assign y_abs = item.point_y[31] ? 32'(-item.point_y) : item.point_y;

	// Restoring step: the remainder stays below the divisor, so 31 bits hold it.
	assign tx  = {rx_q, qx_q[31]};
	assign ty  = {ry_q, qy_q[31]};
	assign gex = tx >= {1'b0, dvs_q};
	assign gey = ty >= {1'b0, dvs_q};

	assign idle       = state_q == F_IDLE;
	assign push_valid = state_q == F_PUSH;

	always_comb begin
		push_data.opcode = op_q;
		push_data.cx     = negx_q ? 32'(-qx_q) : qx_q;
		push_data.cy     = negy_q ? 32'(-qy_q) : qy_q;
		push_data.z      = z_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			dcnt_q  <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (take) begin
						state_q <= F_DIV;
						dcnt_q  <= '0;
					end
				end
				F_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == 5'd31) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && take) begin
			op_q   <= item.opcode;
			z_q    <= item.point_z;
			dvs_q  <= (cfg.cell_size == '0) ? 31'd1 : cfg.cell_size;
			qx_q   <= x_abs;
			qy_q   <= y_abs;
			rx_q   <= '0;
			ry_q   <= '0;
			negx_q <= item.point_x[31];
			negy_q <= item.point_y[31];
		end else if (state_q == F_DIV) begin
			qx_q <= {qx_q[30:0], gex};
			qy_q <= {qy_q[30:0], gey};
			rx_q <= gex ? 31'(tx - {1'b0, dvs_q}) : tx[30:0];
			ry_q <= gey ? 31'(ty - {1'b0, dvs_q}) : ty[30:0];
		end
	end

endmodule

@@ sv/gpc_back.sv @@
// Back part: clears, probes and updates the hashed slot table and classifies
// cells from their truncated means. Depends on gpc_pkg and gpc_ram.
module gpc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  gpc_pkg::cfg_t      cfg,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  gpc_pkg::job_t      pop_data,
	output logic               init,
	output logic               result_valid,
	output gpc_pkg::out_item_t result
);

	typedef enum logic [10:0] {
		B_INIT  = 11'b000_0000_0001,
		B_IDLE  = 11'b000_0000_0010,
		B_CLR   = 11'b000_0000_0100,
		B_HASHX = 11'b000_0000_1000,
		B_HASHY = 11'b000_0001_0000,
		B_START = 11'b000_0010_0000,
		B_RD    = 11'b000_0100_0000,
		B_CHK   = 11'b000_1000_0000,
		B_DIV   = 11'b001_0000_0000,
		B_MEAN  = 11'b010_0000_0000,
		B_NEXT  = 11'b100_0000_0000
	} bstate_t;

	localparam int SB = gpc_pkg::SLOT_BITS;
	localparam int CB = gpc_pkg::COUNT_BITS;
	localparam int WB = gpc_pkg::SUM_BITS;

	bstate_t                   state_q;
	gpc_pkg::job_t             job_q;
	logic [31:0]               tcx_q, tcy_q;
	logic [31:0]               hx_q, hy_q;
	logic [SB-1:0]             slot_q, n_q, clr_q;
	logic                      nbr_q;
	logic [2:0]                k_q;
	logic [3:0]                passes_q;
	logic [WB-1:0]             quo_q;
	logic [CB-1:0]             rem_q, dvs_q;
	logic                      dneg_q;
	logic [gpc_pkg::DCNT_BITS-1:0] dcnt_q;
	logic signed [WB-1:0]      mine_q;
	logic                      res_valid_q;
	gpc_pkg::out_item_t        res_q;

	logic                      ram_we;
	logic [SB-1:0]             ram_addr;
	gpc_pkg::slot_t            ram_wdata;
	logic [gpc_pkg::SLOT_W-1:0] ram_rdata;
	gpc_pkg::slot_t            rd;

	logic                      key_hit, n_last, clr_last, is_accum, pass;
	logic [31:0]               hsh;
	logic signed [WB:0]        sat_t;
	logic signed [WB-1:0]      sat_sum;
	logic [WB-1:0]             sum_abs;
	logic [CB:0]               dt;
	logic                      dge;
	logic signed [WB-1:0]      mean;
	logic signed [gpc_pkg::DIFF_BITS-1:0] diff;

	gpc_ram #(
		.WIDTH(gpc_pkg::SLOT_W),
		.DEPTH(gpc_pkg::CELL_SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign rd       = gpc_pkg::slot_t'(ram_rdata);
	assign key_hit  = rd.valid && rd.cx == tcx_q && rd.cy == tcy_q;
	assign n_last   = n_q == SB'(gpc_pkg::CELL_SLOTS - 1);
	assign clr_last = clr_q == SB'(gpc_pkg::CELL_SLOTS - 1);
	assign is_accum = job_q.opcode == gpc_pkg::OP_ACCUM;
	assign hsh      = (hx_q ^ hy_q) & gpc_pkg::HASH_MASK;

	// The sum saturates: a carry into the extra bit marks the overflow side.
	assign sat_t   = (WB + 1)'(rd.sum) + (WB + 1)'(job_q.z);
	assign sat_sum = (sat_t[WB] != sat_t[WB-1]) ?
		(sat_t[WB] ? {1'b1, {(WB-1){1'b0}}} : {1'b0, {(WB-1){1'b1}}}) : sat_t[WB-1:0];
	assign sum_abs = rd.sum[WB-1] ? WB'(-rd.sum) : rd.sum;

	assign dt   = {rem_q, quo_q[WB-1]};
	assign dge  = dt >= {1'b0, dvs_q};
	assign mean = (dvs_q == '0) ? '0 : (dneg_q ? -$signed(quo_q) : $signed(quo_q));
	assign diff = gpc_pkg::DIFF_BITS'(mine_q) - gpc_pkg::DIFF_BITS'(mean);
	assign pass = diff > gpc_pkg::DIFF_BITS'(cfg.min_rel) &&
		diff < gpc_pkg::DIFF_BITS'(cfg.max_rel);

	assign pop_ready    = state_q == B_IDLE;
	assign init         = state_q == B_INIT;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = slot_q;
		ram_wdata = rd;
		case (state_q)
			B_INIT, B_CLR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
			end
			B_CHK: begin
				if (is_accum && !rd.valid) begin
					ram_we          = 1'b1;
					ram_wdata.valid = 1'b1;
					ram_wdata.cx    = tcx_q;
					ram_wdata.cy    = tcy_q;
					ram_wdata.count = CB'(1);
					ram_wdata.sum   = WB'(job_q.z);
				end else if (is_accum && key_hit && rd.count < gpc_pkg::COUNT_MAX) begin
					ram_we          = 1'b1;
					ram_wdata.count = rd.count + 1'b1;
					ram_wdata.sum   = sat_sum;
				end
			end
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_INIT;
			job_q       <= '0;
			tcx_q       <= '0;
			tcy_q       <= '0;
			hx_q        <= '0;
			hy_q        <= '0;
			slot_q      <= '0;
			n_q         <= '0;
			clr_q       <= '0;
			nbr_q       <= 1'b0;
			k_q         <= '0;
			passes_q    <= '0;
			quo_q       <= '0;
			rem_q       <= '0;
			dvs_q       <= '0;
			dneg_q      <= 1'b0;
			dcnt_q      <= '0;
			mine_q      <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				B_INIT: begin
					clr_q <= clr_q + 1'b1;
					if (clr_last) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (pop_valid) begin
						job_q    <= pop_data;
						tcx_q    <= pop_data.cx;
						tcy_q    <= pop_data.cy;
						nbr_q    <= 1'b0;
						passes_q <= '0;
						clr_q    <= '0;
						case (pop_data.opcode)
							gpc_pkg::OP_CLEAR: state_q <= B_CLR;
							gpc_pkg::OP_ACCUM, gpc_pkg::OP_CLASSIFY: state_q <= B_HASHX;
							default: begin
								res_valid_q <= 1'b1;
								res_q       <= '{status: gpc_pkg::ST_OK, pass_count: 4'd0};
							end
						endcase
					end
				end
				B_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_last) begin
						res_valid_q <= 1'b1;
						res_q       <= '{status: gpc_pkg::ST_OK, pass_count: 4'd0};
						state_q     <= B_IDLE;
					end
				end
				B_HASHX: begin
					hx_q    <= 32'(tcx_q * gpc_pkg::HASH_MUL_X);
					state_q <= B_HASHY;
				end
				B_HASHY: begin
					hy_q    <= 32'(tcy_q * gpc_pkg::HASH_MUL_Y);
					state_q <= B_START;
				end
				B_START: begin
					slot_q  <= SB'(hsh[gpc_pkg::IDX_BITS-1:0]);
					n_q     <= '0;
					state_q <= B_RD;
				end
				B_RD: state_q <= B_CHK;
				B_CHK: begin
					if (key_hit) begin
						if (is_accum) begin
							res_valid_q <= 1'b1;
							res_q       <= '{status: gpc_pkg::ST_OK, pass_count: 4'd0};
							state_q     <= B_IDLE;
						end else if (!nbr_q &&
							gpc_pkg::CMP_BITS'(rd.count) < gpc_pkg::CMP_BITS'(cfg.min_pts)) begin
							res_valid_q <= 1'b1;
							res_q       <= '{status: gpc_pkg::ST_FEW, pass_count: 4'd0};
							state_q     <= B_IDLE;
						end else begin
							quo_q   <= sum_abs;
							rem_q   <= '0;
							dvs_q   <= rd.count;
							dneg_q  <= rd.sum[WB-1];
							dcnt_q  <= '0;
							state_q <= B_DIV;
						end
					end else if (!rd.valid || n_last) begin
						if (is_accum) begin
							res_valid_q <= 1'b1;
							res_q <= '{status: rd.valid ? gpc_pkg::ST_FULL : gpc_pkg::ST_OK,
								pass_count: 4'd0};
							state_q <= B_IDLE;
						end else if (!nbr_q) begin
							res_valid_q <= 1'b1;
							res_q       <= '{status: gpc_pkg::ST_ABSENT, pass_count: 4'd0};
							state_q     <= B_IDLE;
						end else begin
							state_q <= B_NEXT;
						end
					end else begin
						slot_q  <= slot_q + 1'b1;
						n_q     <= n_q + 1'b1;
						state_q <= B_RD;
					end
				end
				B_DIV: begin
					quo_q  <= {quo_q[WB-2:0], dge};
					rem_q  <= dge ? CB'(dt - {1'b0, dvs_q}) : dt[CB-1:0];
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == gpc_pkg::DCNT_BITS'(WB - 1)) begin
						state_q <= B_MEAN;
					end
				end
				B_MEAN: begin
					if (!nbr_q) begin
						mine_q  <= mean;
						nbr_q   <= 1'b1;
						k_q     <= '0;
						tcx_q   <= job_q.cx + gpc_pkg::nbr_dx(3'd0);
						tcy_q   <= job_q.cy + gpc_pkg::nbr_dy(3'd0);
						state_q <= B_HASHX;
					end else begin
						if (pass) begin
							passes_q <= passes_q + 1'b1;
						end
						state_q <= B_NEXT;
					end
				end
				B_NEXT: begin
					if (k_q == 3'(gpc_pkg::NBR_COUNT - 1)) begin
						res_valid_q <= 1'b1;
						res_q <= '{status: (passes_q >= cfg.min_pass) ? gpc_pkg::ST_POLE :
							gpc_pkg::ST_NOT_POLE, pass_count: passes_q};
						state_q <= B_IDLE;
					end else begin
						k_q     <= k_q + 1'b1;
						tcx_q   <= job_q.cx + gpc_pkg::nbr_dx(k_q + 1'b1);
						tcy_q   <= job_q.cy + gpc_pkg::nbr_dy(k_q + 1'b1);
						state_q <= B_HASHX;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

@@ sv/grid_pole_classifier_core.sv @@
// Top level of the grid pole classifier: configuration registers, front,
// job queue and back. Depends on gpc_pkg, gpc_front, gpc_fifo and gpc_back.
//
//   channel   handshake                 payload
//   command   start / busy              item   (gpc_pkg::in_item_t)
//   result    result_valid (strobe)     result (gpc_pkg::out_item_t)
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// The front takes each item, runs 32 division steps and queues the job; it
// waits while the queue is full. Back: clear sweeps every slot; accumulate
// hashes the cell, then reads and checks each probed slot. Classify does so for
// each looked-up cell and divides out the mean of each present cell. After reset
// a sweep over all CELL_SLOTS slots empties the table, with busy high.
// The queue holds two jobs; the receiver of results cannot stall.
module grid_pole_classifier_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  gpc_pkg::in_item_t  item,
	output logic               result_valid,
	output gpc_pkg::out_item_t result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	gpc_pkg::cfg_t cfg_q;
	logic          front_idle, back_init, take;
	logic          push_valid, push_ready, pop_valid, pop_ready;
	gpc_pkg::job_t push_data, pop_data;

	assign cfg_ready = 1'b1;
	assign busy      = !front_idle || back_init;
	assign take      = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cell_size <= gpc_pkg::RST_CELL_SIZE;
			cfg_q.min_rel   <= gpc_pkg::RST_MIN_REL;
			cfg_q.max_rel   <= gpc_pkg::RST_MAX_REL;
			cfg_q.min_pts   <= gpc_pkg::RST_MIN_PTS;
			cfg_q.min_pass  <= gpc_pkg::RST_MIN_PASS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gpc_pkg::CFG_CELL_SIZE: cfg_q.cell_size <= cfg_data[30:0];
				gpc_pkg::CFG_MIN_REL:   cfg_q.min_rel   <= cfg_data;
				gpc_pkg::CFG_MAX_REL:   cfg_q.max_rel   <= cfg_data;
				gpc_pkg::CFG_MIN_PTS:   cfg_q.min_pts   <= cfg_data[15:0];
				gpc_pkg::CFG_MIN_PASS:  cfg_q.min_pass  <= cfg_data[3:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	gpc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.item       (item),
		.cfg        (cfg_q),
		.idle       (front_idle),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	gpc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	gpc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.init         (back_init),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

@@ sv/gpc_checker.sv @@
// Port-level checker for the grid pole classifier, bound to the top level.
// Depends on gpc_pkg for the result type, status codes, queue depth and neighbor count.
module gpc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               result_valid,
	input gpc_pkg::out_item_t result
);

	logic [3:0] outstanding_q;
	logic       acc;

	assign acc = start && !busy;

	// Items taken whose result beat has not yet gone out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else if (acc && !result_valid) begin
			outstanding_q <= outstanding_q + 1'b1;
		end else if (result_valid && !acc) begin
			outstanding_q <= outstanding_q - 1'b1;
		end
	end

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> outstanding_q != '0)
		else $error("result beat without an outstanding item");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= 4'(gpc_pkg::QUEUE_DEPTH + 2))
		else $error("more items in flight than the block can hold");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> busy)
		else $error("busy did not rise after an item was taken");

	a_pass_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !(result.status == gpc_pkg::ST_POLE ||
		result.status == gpc_pkg::ST_NOT_POLE) |-> result.pass_count == 4'd0)
		else $error("pass count set on a result that is not a classification");

	a_pass_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.pass_count <= 4'(gpc_pkg::NBR_COUNT))
		else $error("pass count above the neighbor count");

endmodule

bind grid_pole_classifier_core gpc_checker u_gpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);

@@ sim/testbench.sv @@
// Self-checking testbench for grid_pole_classifier_core: directed table and random
// neighborhoods, checked against the answers in the table where given, else an in-bench predictor.
// Depends on gpc_pkg and the grid_pole_classifier_core RTL.
module testbench;
	import gpc_pkg::*;

	localparam int ONE = 65536;

	typedef struct {
		logic        used;
		logic [31:0] kx;
		logic [31:0] ky;
		int          cnt;
		longint      sum;
	} cell_rec_t;

	typedef struct {
		bit          cfg_en;
		cfg_idx_e    ci;
		logic [31:0] cd;
		op_e         op;
		int          x;
		int          y;
		int          z;
		bit          typed;
		status_e     st;
		logic [3:0]  pc;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_item_t    item;
	logic        result_valid;
	out_item_t   result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	grid_pole_classifier_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predicted cell table and register copies.
	cell_rec_t   grid[CELL_SLOTS];
	logic [30:0] cs;
	int          rel_lo;
	int          rel_hi;
	logic [15:0] pts_min;
	logic [3:0]  pass_min;

	out_item_t   pending[$];
	bit          bad;
	int          idle_pct;
	int          sent;
	row_t        dir[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#500000000;
		$display("grid_pole_classifier_core: mismatch");
		$finish;
	end

	function automatic logic [31:0] grid_index(logic signed [31:0] v);
		longint d;
		longint q;
		d = (cs == 0) ? 1 : longint'(cs);
		q = longint'(v) / d;
		return q[31:0];
	endfunction

	function automatic int find_slot(logic [31:0] cx, logic [31:0] cy, output bit hit);
		logic [31:0] h;
		int s;
		hit = 1'b0;
		h = HASH_MASK & ((cx * HASH_MUL_X) ^ (cy * HASH_MUL_Y));
		s = int'(h % (1 << HASH_BITS)) % CELL_SLOTS;
		for (int n = 0; n < CELL_SLOTS; n++) begin
			if (!grid[s].used)
				return s;
			if (grid[s].kx == cx && grid[s].ky == cy) begin
				hit = 1'b1;
				return s;
			end
			s = (s + 1) % CELL_SLOTS;
		end
		return -1;
	endfunction

	function automatic longint cell_avg(int s);
		return grid[s].cnt ? grid[s].sum / longint'(grid[s].cnt) : 0;
	endfunction

	// Applies one command to the predicted table and returns its answer.
	function automatic out_item_t classify_step(in_item_t it);
		logic [31:0] cx;
		logic [31:0] cy;
		int s;
		int ns;
		bit hit;
		bit nhit;
		longint t;
		longint mine;
		longint diff;
		int passes;
		out_item_t r;
		r = '0;
		passes = 0;
		cx = grid_index(it.point_x);
		cy = grid_index(it.point_y);
		case (op_e'(it.opcode))
			OP_CLEAR: begin
				foreach (grid[i])
					grid[i].used = 1'b0;
			end
			OP_ACCUM: begin
				s = find_slot(cx, cy, hit);
				if (s < 0) begin
					r.status = ST_FULL;
				end else if (!hit) begin
					grid[s].used = 1'b1;
					grid[s].kx = cx;
					grid[s].ky = cy;
					grid[s].cnt = 1;
					grid[s].sum = longint'(it.point_z);
				end else if (grid[s].cnt < int'(COUNT_MAX)) begin
					t = grid[s].sum + longint'(it.point_z);
					if (t > 64'sh7FFF_FFFF_FFFF)
						t = 64'sh7FFF_FFFF_FFFF;
					if (t < -64'sh8000_0000_0000)
						t = -64'sh8000_0000_0000;
					grid[s].sum = t;
					grid[s].cnt++;
				end
			end
			OP_CLASSIFY: begin
				s = find_slot(cx, cy, hit);
				if (s < 0 || !hit) begin
					r.status = ST_ABSENT;
				end else if (grid[s].cnt < int'(pts_min)) begin
					r.status = ST_FEW;
				end else begin
					mine = cell_avg(s);
					for (int dx = -1; dx <= 1; dx++) begin
						for (int dy = -1; dy <= 1; dy++) begin
							if (dx != 0 || dy != 0) begin
								ns = find_slot(cx + dx, cy + dy, nhit);
								if (ns >= 0 && nhit) begin
									diff = mine - cell_avg(ns);
									if (diff > longint'(rel_lo) && diff < longint'(rel_hi))
										passes++;
								end
							end
						end
					end
					r.status = (passes >= int'(pass_min)) ? ST_POLE : ST_NOT_POLE;
					r.pass_count = passes[3:0];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic add_row(input row_t r);
		dir = {dir, r};
	endtask

	task automatic issue(input in_item_t it, input bit typed, input out_item_t want);
		out_item_t p;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		p = classify_step(it);
		pending = {pending, typed ? want : p};
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
	endtask

	// Register writes only happen with the block idle.
	task automatic write_reg(input cfg_idx_e idx, input logic [31:0] d);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_CELL_SIZE: cs = d[30:0];
			CFG_MIN_REL:   rel_lo = int'(d);
			CFG_MAX_REL:   rel_hi = int'(d);
			CFG_MIN_PTS:   pts_min = d[15:0];
			CFG_MIN_PASS:  pass_min = d[3:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_op(input op_e op, input int x, input int y, input int z);
		in_item_t it;
		it.opcode = op;
		it.point_x = x;
		it.point_y = y;
		it.point_z = z;
		issue(it, 1'b0, '0);
		sent++;
	endtask

	// A coordinate that falls in cell c; cell zero spans both signs.
	function automatic int place(longint c, longint csz);
		longint r;
		longint x;
		r = longint'($urandom_range(0, csz - 1));
		if (c > 0 || (c == 0 && $urandom_range(1)))
			x = c * csz + r;
		else
			x = c * csz - r;
		if (x > 2147483647)
			x = 2147483647;
		if (x < -2147483648)
			x = -2147483648;
		return int'(x);
	endfunction

	// A 3x3 neighborhood of cells with random heights, then a few lookups in it.
	task automatic survey_patch();
		longint csz;
		longint lim;
		longint bx;
		longint by;
		int base_z[3][3];
		int n;
		int px;
		int py;
		csz = (cs == 0) ? 1 : longint'(cs);
		lim = 2147483647 / csz - 2;
		if (lim < 0)
			lim = 0;
		if (lim > 50)
			lim = 50;
		bx = longint'($urandom_range(0, 2 * lim)) - lim;
		by = longint'($urandom_range(0, 2 * lim)) - lim;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				base_z[i][j] = (i == 1 && j == 1) ? int'($urandom_range(0, 4 * ONE))
					: int'($urandom_range(0, ONE)) - ONE / 4;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				n = (i == 1 && j == 1) ? $urandom_range(0, 6) : $urandom_range(0, 3);
				repeat (n)
					send_op(OP_ACCUM, place(bx + i - 1, csz), place(by + j - 1, csz),
						base_z[i][j] + int'($urandom_range(0, 8191)) - 4096);
			end
		end
		repeat ($urandom_range(1, 3)) begin
			px = ($urandom_range(3) == 0) ? $urandom_range(0, 2) : 1;
			py = ($urandom_range(3) == 0) ? $urandom_range(0, 2) : 1;
			send_op(OP_CLASSIFY, place(bx + px - 1, csz), place(by + py - 1, csz),
				int'($urandom));
		end
	endtask

	task automatic stray_item();
		int r;
		op_e op;
		r = $urandom_range(99);
		op = (r < 2) ? OP_CLEAR : (r < 30) ? OP_NONE : (r < 65) ? OP_ACCUM : OP_CLASSIFY;
		send_op(op, int'($urandom), int'($urandom), int'($urandom));
	endtask

	always @(posedge clk) begin
		out_item_t w;
		if (arst_n && result_valid) begin
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time, result);
				bad = 1'b1;
			end else begin
				w = pending.pop_front();
				if (result.status !== w.status) begin
					$display("%0t: status expected %0d actual %0d", $time, w.status,
						result.status);
					bad = 1'b1;
				end
				if (result.pass_count !== w.pass_count) begin
					$display("%0t: pass_count expected %0d actual %0d", $time, w.pass_count,
						result.pass_count);
					bad = 1'b1;
				end
			end
		end
	end

	initial begin
		in_item_t it;
		out_item_t want;
		int target;
		arst_n <= 1'b0;
		start <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_CELL_SIZE;
		cfg_data <= '0;
		bad = 1'b0;
		sent = 0;
		idle_pct = 20;
		foreach (grid[i])
			grid[i] = '{1'b0, 32'd0, 32'd0, 0, 0};
		cs = RST_CELL_SIZE;
		rel_lo = RST_MIN_REL;
		rel_hi = RST_MAX_REL;
		pts_min = RST_MIN_PTS;
		pass_min = RST_MIN_PASS;

		// Directed rows: center cell at 2.0 over eight neighbors at 0.0 makes a full pole.
		add_row('{0, CFG_CELL_SIZE, 0, OP_CLASSIFY, 0, 0, 0, 1, ST_ABSENT, 0});
		add_row('{0, CFG_CELL_SIZE, 0, OP_NONE, -1, -1, -1, 1, ST_OK, 0});
		add_row('{0, CFG_CELL_SIZE, 0, OP_ACCUM, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF, 1, ST_OK, 0});
		add_row('{0, CFG_CELL_SIZE, 0, OP_ACCUM, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000, 1, ST_OK, 0});
		add_row('{0, CFG_CELL_SIZE, 0, OP_ACCUM, 0, 0, 2 * ONE, 1, ST_OK, 0});
		add_row('{0, CFG_CELL_SIZE, 0, OP_ACCUM, ONE - 1, 5, 2 * ONE, 1, ST_OK, 0});
		add_row('{0, CFG_CELL_SIZE, 0, OP_ACCUM, 1 - ONE, -5, 2 * ONE, 1, ST_OK, 0});
		add_row('{0, CFG_CELL_SIZE, 0, OP_ACCUM, -ONE, -ONE, 0, 1, ST_OK, 0});
		add_row('{0, CFG_CELL_SIZE, 0, OP_ACCUM, -ONE, 0, 0, 1, ST_OK, 0});
		add_row('{0, CFG_CELL_SIZE, 0, OP_ACCUM, -ONE, ONE, 0, 1, ST_OK, 0});
		add_row('{0, CFG_CELL_SIZE, 0, OP_ACCUM, 0, -ONE, 0, 1, ST_OK, 0});
		add_row('{0, CFG_CELL_SIZE, 0, OP_ACCUM, 0, ONE, 0, 1, ST_OK, 0});
		add_row('{0, CFG_CELL_SIZE, 0, OP_ACCUM, ONE, -ONE, 0, 1, ST_OK, 0});
		add_row('{0, CFG_CELL_SIZE, 0, OP_ACCUM, ONE, 0, 0, 1, ST_OK, 0});
		add_row('{0, CFG_CELL_SIZE, 0, OP_ACCUM, ONE, ONE, 0, 1, ST_OK, 0});
		add_row('{0, CFG_CELL_SIZE, 0, OP_CLASSIFY, 100, 200, 0, 1, ST_POLE, 8});
		add_row('{0, CFG_CELL_SIZE, 0, OP_CLASSIFY, -ONE, -ONE, 0, 1, ST_FEW, 0});
		add_row('{0, CFG_CELL_SIZE, 0, OP_CLASSIFY, -1, -1, 0, 0, ST_OK, 0});
		add_row('{0, CFG_CELL_SIZE, 0, OP_CLEAR, 3, 4, 5, 1, ST_OK, 0});
		add_row('{0, CFG_CELL_SIZE, 0, OP_CLASSIFY, 0, 0, 0, 1, ST_ABSENT, 0});
		// Unit cells: the neighbor of the largest index wraps to the smallest one.
		add_row('{1, CFG_CELL_SIZE, 1, OP_ACCUM, 32'h7FFFFFFF, 0, 5 * ONE, 1, ST_OK, 0});
		add_row('{0, CFG_CELL_SIZE, 0, OP_ACCUM, 32'h7FFFFFFF, 0, 5 * ONE, 0, ST_OK, 0});
		add_row('{0, CFG_CELL_SIZE, 0, OP_ACCUM, 32'h7FFFFFFF, 0, 5 * ONE, 0, ST_OK, 0});
		add_row('{0, CFG_CELL_SIZE, 0, OP_ACCUM, 32'h80000000, 0, 3 * ONE, 0, ST_OK, 0});
		add_row('{0, CFG_CELL_SIZE, 0, OP_CLASSIFY, 32'h7FFFFFFF, 0, 0, 0, ST_OK, 0});
		add_row('{1, CFG_MIN_PASS, 15, OP_CLASSIFY, 32'h7FFFFFFF, 0, 0, 0, ST_OK, 0});
		add_row('{1, CFG_CELL_SIZE, 0, OP_CLASSIFY, 32'h7FFFFFFF, 0, 0, 0, ST_OK, 0});
		add_row('{1, CFG_MIN_PASS, 0, OP_CLASSIFY, 32'h7FFFFFFF, 0, 0, 0, ST_OK, 0});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir[i]) begin
			if (dir[i].cfg_en)
				write_reg(dir[i].ci, dir[i].cd);
			it.opcode = dir[i].op;
			it.point_x = dir[i].x;
			it.point_y = dir[i].y;
			it.point_z = dir[i].z;
			want.status = dir[i].st;
			want.pass_count = dir[i].pc;
			issue(it, dir[i].typed, want);
		end

		sent = 0;
		for (int p = 0; p < 6; p++) begin
			idle_pct = (p < 2) ? 20 : (p < 4) ? 72 : 0;
			case (p)
				0: begin
					write_reg(CFG_CELL_SIZE, $urandom_range(1, 4 * ONE));
					write_reg(CFG_MIN_REL, 32'h80000000);
					write_reg(CFG_MAX_REL, 32'h7FFFFFFF);
					write_reg(CFG_MIN_PTS, 0);
					write_reg(CFG_MIN_PASS, 8);
				end
				1: begin
					write_reg(CFG_CELL_SIZE, 32'hFFFFFFFF);
					write_reg(CFG_MIN_REL, 32'h7FFFFFFF);
					write_reg(CFG_MAX_REL, 32'h80000000);
					write_reg(CFG_MIN_PTS, 16'hFFFF);
					write_reg(CFG_MIN_PASS, 0);
				end
				default: begin
					write_reg(CFG_CELL_SIZE, ($urandom_range(3) == 0) ? 1 : $urandom_range(1, 16 * ONE));
					rel_lo = int'($urandom_range(0, 2 * ONE)) - ONE / 2;
					write_reg(CFG_MIN_REL, rel_lo);
					write_reg(CFG_MAX_REL, rel_lo + int'($urandom_range(ONE, 6 * ONE)));
					write_reg(CFG_MIN_PTS, $urandom_range(0, 4));
					write_reg(CFG_MIN_PASS, $urandom_range(0, 9));
				end
			endcase
			send_op(OP_CLEAR, 0, 0, 0);
			target = sent + 115;
			while (sent < target) begin
				if ($urandom_range(99) < 12)
					stray_item();
				else
					survey_patch();
			end
		end

		drain();
		repeat (50) @(posedge clk);
		if (!bad)
			$display("grid_pole_classifier_core: match");
		else
			$display("grid_pole_classifier_core: mismatch");
		$finish;
	end

endmodule

@@ grid_pole_classifier_core.f @@
sv/gpc_pkg.sv
sv/gpc_ram.sv
sv/gpc_fifo.sv
sv/gpc_front.sv
sv/gpc_back.sv
sv/grid_pole_classifier_core.sv
sv/gpc_checker.sv
sim/testbench.sv
